[hw/rtl/abaf_pkg.sv]
package abaf_pkg;

  localparam int unsigned DEFAULT_LOOP_DEPTH  = 2048;
  localparam int unsigned DEFAULT_LARGE_BLOCK = 128;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CAPLEN_W = 12;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AVG2   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AVG8   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVGL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FREEZE = 3'd4;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_CAPLEN = 1'b1;

  localparam logic [CAPLEN_W-1:0] CAPLEN_RESET = 12'd2048;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CAPLEN_W-1:0] capture_length;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } loop_ctrl_t;

endpackage

[hw/rtl/abaf_regs.sv]
module abaf_regs
  import abaf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [CAPLEN_W-1:0] caplen_q, caplen_d;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    mode_d   = mode_q;
    caplen_d = caplen_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MODE:   mode_d   = pwdata[MODE_W-1:0];
        REG_CAPLEN: caplen_d = pwdata[CAPLEN_W-1:0];
        default:    mode_d   = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BYPASS;
      caplen_q <= CAPLEN_RESET;
    end else begin
      mode_q   <= mode_d;
      caplen_q <= caplen_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_CAPLEN: prdata = APB_DW'(caplen_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.mode           = mode_q;
  assign cfg_o.capture_length = caplen_q;

endmodule

[hw/rtl/abaf_avg.sv]
module abaf_avg
  import abaf_pkg::*;
#(
  parameter int unsigned LARGE_BLOCK = DEFAULT_LARGE_BLOCK
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SAMPLE_W-1:0] held_o
);

  localparam int unsigned PW       = $clog2(LARGE_BLOCK);
  localparam int unsigned LB_SHIFT = $clog2(LARGE_BLOCK);
  localparam int unsigned KSH      = SAMPLE_W + LB_SHIFT;
  localparam longint unsigned RECIP_VAL = ((64'd1 << KSH) / LARGE_BLOCK) + 64'd1;
  localparam int unsigned RW       = $clog2(RECIP_VAL + 1);
  localparam logic [RW-1:0] RECIP  = RW'(RECIP_VAL);
  localparam logic [PW-1:0] LAST2  = PW'(1);
  localparam logic [PW-1:0] LAST8  = PW'(7);
  localparam logic [PW-1:0] LASTL  = PW'(LARGE_BLOCK - 1);

  logic [SAMPLE_W-1:0]    sum_q, sum_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [SAMPLE_W-1:0]    held_q, held_d;
  logic                   neg;
  logic [SAMPLE_W:0]      sx;
  logic [SAMPLE_W:0]      q2_full, q8_full;
  logic [SAMPLE_W-1:0]    mag;
  logic [SAMPLE_W+RW-1:0] prod;
  logic [SAMPLE_W-1:0]    qm, ql;
  logic [SAMPLE_W-1:0]    quot;
  logic [PW-1:0]          last_pos;
  logic                   active;
  logic [SAMPLE_W-1:0]    new_sum;

  assign neg = sample_i[SAMPLE_W-1];
  assign sx  = {sample_i[SAMPLE_W-1], sample_i};

  assign q2_full = $signed(sx + (neg ? (SAMPLE_W+1)'(1) : '0)) >>> 1;
  assign q8_full = $signed(sx + (neg ? (SAMPLE_W+1)'(7) : '0)) >>> 3;

  assign mag  = neg ? SAMPLE_W'(-sx) : sample_i;
  assign prod = (SAMPLE_W+RW)'(mag) * (SAMPLE_W+RW)'(RECIP);
  assign qm   = SAMPLE_W'(prod >> KSH);
  assign ql   = neg ? (~qm + SAMPLE_W'(1)) : qm;

  always_comb begin
    active   = 1'b1;
    quot     = '0;
    last_pos = LAST2;
    case (mode_i)
      MODE_AVG2: begin
        quot     = q2_full[SAMPLE_W-1:0];
        last_pos = LAST2;
      end
      MODE_AVG8: begin
        quot     = q8_full[SAMPLE_W-1:0];
        last_pos = LAST8;
      end
      MODE_AVGL: begin
        quot     = ql;
        last_pos = LASTL;
      end
      default: active = 1'b0;
    endcase
  end

  assign new_sum = sum_q + quot;

  always_comb begin
    sum_d  = sum_q;
    pos_d  = pos_q;
    held_d = held_q;
    if (step_i && active) begin
      if (pos_q >= last_pos) begin
        held_d = new_sum;
        sum_d  = '0;
        pos_d  = '0;
      end else begin
        sum_d = new_sum;
        pos_d = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pos_q  <= '0;
      held_q <= '0;
    end else begin
      sum_q  <= sum_d;
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

  assign held_o = held_q;

endmodule

[hw/rtl/abaf_loop.sv]
module abaf_loop
  import abaf_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH = DEFAULT_LOOP_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [CAPLEN_W-1:0] caplen_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                playing_o,
  output logic [SAMPLE_W-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(LOOP_DEPTH);
  localparam int unsigned CW = (AW + 1 > CAPLEN_W) ? AW + 1 : CAPLEN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(LOOP_DEPTH);

  logic [SAMPLE_W-1:0] mem [LOOP_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                done_q, done_d;
  logic [CW-1:0]       cap_ext, len;
  logic                last;
  loop_ctrl_t          ctrl;

  assign cap_ext = CW'(caplen_i);

  always_comb begin
    if (cap_ext == '0) begin
      len = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      len = DEPTH_C;
    end else begin
      len = cap_ext;
    end
  end

  assign last       = (CW'(ptr_q) + CW'(1)) >= len;
  assign ctrl.wr_en = step_i & ~done_q;
  assign ctrl.rd_en = step_i & done_q;

  always_comb begin
    ptr_d  = ptr_q;
    done_d = done_q;
    if (step_i) begin
      ptr_d = last ? '0 : ptr_q + AW'(1);
      if (!done_q && last) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wr_en) begin
      mem[ptr_q] <= sample_i;
    end
    if (ctrl.rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  assign playing_o = done_q;
  assign rdata_o   = rdata_q;

endmodule

[hw/rtl/audio_block_average_and_freeze_core.sv]
// Audio block averager with a freeze loop. Samples enter on a valid/ready
// channel and leave on another; each input transaction yields exactly one
// output transaction, in order. The APB port sets the mode and the capture
// length and may only be written while no transaction is in flight.
// A result passes through the read stage, where the loop memory read data is registered,
// and then through the output register before it can be taken from the output.
// One sample is accepted every cycle in steady state while the receiver does not stall.
// The averaging state sits in registers and is updated as each sample is
// accepted; block averages therefore lag by one block. In freeze mode the
// first samples are written to the loop memory and then read back in turn.
// Reset clears the pipeline, the averager and the loop pointer; the loop
// memory is not cleared and is simply rewritten by the next capture.
// When the receiver stalls, the output register holds its transaction,
// one further sample may be accepted into the read stage, and input ready
// then falls until the output register drains.
module audio_block_average_and_freeze_core
  import abaf_pkg::*;
#(
  parameter int unsigned LOOP_DEPTH  = DEFAULT_LOOP_DEPTH,
  parameter int unsigned LARGE_BLOCK = DEFAULT_LARGE_BLOCK
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] out_sample_o
);

  cfg_t                cfg;
  logic                accept;
  logic                avg_step, loop_step;
  logic                is_freeze;
  logic [SAMPLE_W-1:0] held;
  logic                playing;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_mem_q, s1_mem_d;
  logic [SAMPLE_W-1:0] s1_data_q, s1_data_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                out_load;

  abaf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_load   = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | out_load;
  assign accept     = in_valid_i & in_ready_o;
  assign is_freeze  = (cfg.mode == MODE_FREEZE);
  assign avg_step   = accept;
  assign loop_step  = accept & is_freeze;

  abaf_avg #(
    .LARGE_BLOCK (LARGE_BLOCK)
  ) u_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (avg_step),
    .mode_i   (cfg.mode),
    .sample_i (in_sample_i),
    .held_o   (held)
  );

  abaf_loop #(
    .LOOP_DEPTH (LOOP_DEPTH)
  ) u_loop (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (loop_step),
    .caplen_i  (cfg.capture_length),
    .sample_i  (in_sample_i),
    .playing_o (playing),
    .rdata_o   (mem_rdata)
  );

  always_comb begin
    s1_mem_d  = s1_mem_q;
    s1_data_d = s1_data_q;
    if (accept) begin
      s1_mem_d = 1'b0;
      case (cfg.mode)
        MODE_AVG2, MODE_AVG8, MODE_AVGL: s1_data_d = held;
        MODE_FREEZE: begin
          s1_data_d = in_sample_i;
          s1_mem_d  = playing;
        end
        default: s1_data_d = in_sample_i;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = s1_mem_q ? mem_rdata : s1_data_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mem_q   <= s1_mem_d;
    s1_data_q  <= s1_data_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_data_q;

endmodule

[hw/rtl/abaf_checker.sv]
module abaf_checker
  import abaf_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pready,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] out_sample_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("Output valid during reset.");

  a_pready_high: assert property (@(posedge clk_i) pready)
    else $error("pready dropped.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input not ready although the output register is empty.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sample_o))
    else $error("Stalled output transaction changed.");

endmodule

bind audio_block_average_and_freeze_core abaf_checker u_abaf_checker (.*);

[bench/tb_top.sv]
module tb_top;
  import abaf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned NUM_DIR = 22;
  localparam int unsigned RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CAPLEN_W-1:0] len;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    logic [SAMPLE_W-1:0] result;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
    '{MODE_BYPASS, 12'hFFF, 16'h7FFF, 1'b1, 16'h7FFF},
    '{MODE_BYPASS, 12'hFFF, 16'h8000, 1'b1, 16'h8000},
    '{MODE_SPARE5, 12'hFFF, 16'h1234, 1'b1, 16'h1234},
    '{MODE_SPARE6, 12'hFFF, 16'hFFFF, 1'b1, 16'hFFFF},
    '{MODE_SPARE7, 12'hFFF, 16'h0000, 1'b1, 16'h0000},
    '{MODE_AVG2,   12'hFFF, 16'h7FFF, 1'b1, 16'h0000},
    '{MODE_AVG2,   12'hFFF, 16'h8000, 1'b1, 16'h0000},
    '{MODE_AVG2,   12'hFFF, 16'h0003, 1'b1, 16'hFFFF},
    '{MODE_AVG2,   12'hFFF, 16'hFFFD, 1'b1, 16'hFFFF},
    '{MODE_AVG8,   12'hFFF, 16'h7FFF, 1'b0, 16'h0000},
    '{MODE_AVG8,   12'hFFF, 16'h0008, 1'b0, 16'h0000},
    '{MODE_AVG8,   12'hFFF, 16'hFFF8, 1'b0, 16'h0000},
    '{MODE_AVG8,   12'hFFF, 16'h8000, 1'b0, 16'h0000},
    '{MODE_AVG8,   12'hFFF, 16'h0007, 1'b0, 16'h0000},
    '{MODE_AVG2,   12'hFFF, 16'h1000, 1'b0, 16'h0000},
    '{MODE_AVGL,   12'hFFF, 16'h8000, 1'b0, 16'h0000},
    '{MODE_AVGL,   12'hFFF, 16'h7FFF, 1'b0, 16'h0000},
    '{MODE_FREEZE, 12'hFFF, 16'h1111, 1'b1, 16'h1111},
    '{MODE_FREEZE, 12'hFFF, 16'hEEEE, 1'b1, 16'hEEEE},
    '{MODE_BYPASS, 12'hFFF, 16'h5555, 1'b1, 16'h5555},
    '{MODE_FREEZE, 12'hFFF, 16'h0001, 1'b1, 16'h0001},
    '{MODE_FREEZE, 12'hFFF, 16'hFFFF, 1'b1, 16'hFFFF}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] in_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0] out_sample_o;

  bit idle_on = 1'b1;
  bit mismatch_seen = 1'b0;
  logic [SAMPLE_W-1:0] expected_out [$];

  logic [MODE_W-1:0]   cur_mode = MODE_BYPASS;
  logic [CAPLEN_W-1:0] cur_len = CAPLEN_RESET;
  logic [SAMPLE_W-1:0] blk_sum = '0;
  logic [SAMPLE_W-1:0] held_avg = '0;
  int unsigned         blk_pos = 0;
  logic [SAMPLE_W-1:0] loop_mem [DEFAULT_LOOP_DEPTH];
  int unsigned         loop_ptr = 0;
  bit                  cap_done = 1'b0;

  audio_block_average_and_freeze_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [SAMPLE_W-1:0] average_step(input logic [SAMPLE_W-1:0] raw,
                                                       input int size);
    logic [SAMPLE_W-1:0] res;
    int                  quot;
    res = held_avg;
    quot = int'($signed(raw)) / size;
    blk_sum = blk_sum + quot[SAMPLE_W-1:0];
    if (blk_pos + 1 >= size) begin
      held_avg = blk_sum;
      blk_sum = '0;
      blk_pos = 0;
    end else begin
      blk_pos++;
    end
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] loop_step(input logic [SAMPLE_W-1:0] raw);
    int unsigned         len;
    int unsigned         idx;
    bit                  last;
    logic [SAMPLE_W-1:0] res;
    len = (cur_len < 1) ? 1 : (cur_len > DEFAULT_LOOP_DEPTH) ? DEFAULT_LOOP_DEPTH : cur_len;
    idx = loop_ptr % DEFAULT_LOOP_DEPTH;
    last = (loop_ptr + 1 >= len);
    if (!cap_done) begin
      loop_mem[idx] = raw;
      res = raw;
      if (last) cap_done = 1'b1;
    end else begin
      res = loop_mem[idx];
    end
    loop_ptr = last ? 0 : loop_ptr + 1;
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_out_sample(input logic [SAMPLE_W-1:0] raw);
    case (cur_mode)
      MODE_AVG2:   return average_step(raw, 2);
      MODE_AVG8:   return average_step(raw, 8);
      MODE_AVGL:   return average_step(raw, DEFAULT_LARGE_BLOCK);
      MODE_FREEZE: return loop_step(raw);
      default:     return raw;
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [APB_DW-1:0] data,
                           input int unsigned bits);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] mask;
    mask = (32'd1 << bits) - 32'd1;
    apb_access(1'b1, {reg_idx, 2'b00}, data, rd);
    apb_access(1'b0, {reg_idx, 2'b00}, '0, rd);
    if ((rd & mask) != (data & mask)) begin
      $error("prdata: expected %h, actual %h", data & mask, rd & mask);
      mismatch_seen = 1'b1;
    end
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [CAPLEN_W-1:0] len);
    if (mode != cur_mode || len != cur_len) begin
      drain();
      if (mode != cur_mode) write_reg(REG_MODE, APB_DW'(mode), MODE_W);
      if (len != cur_len) write_reg(REG_CAPLEN, APB_DW'(len), CAPLEN_W);
      cur_mode = mode;
      cur_len = len;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input logic [SAMPLE_W-1:0] typed_val);
    logic [SAMPLE_W-1:0] pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pred = next_out_sample(s);
    expected_out.push_back(typed ? typed_val : pred);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [CAPLEN_W-1:0] len,
                           input int unsigned n_items, inout int unsigned count);
    logic [SAMPLE_W-1:0] s;
    configure(mode, len);
    for (int unsigned k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 9))
        0:       s = 16'h7FFF;
        1:       s = 16'h8000;
        2:       s = SAMPLE_W'($urandom_range(0, 15));
        3:       s = 16'hFFFF - SAMPLE_W'($urandom_range(0, 15));
        default: s = SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(0, 299) == 0) drain();
      send_sample(s, 1'b0, '0);
      count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        $error("out_sample: expected none, actual %h", out_sample_o);
        mismatch_seen = 1'b1;
      end else if (out_sample_o !== expected_out[0]) begin
        $error("out_sample: expected %h, actual %h", expected_out[0], out_sample_o);
        mismatch_seen = 1'b1;
        void'(expected_out.pop_front());
      end else begin
        void'(expected_out.pop_front());
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0]   ph_mode;
    logic [CAPLEN_W-1:0] ph_len;
    logic [CAPLEN_W-1:0] cap_fix;
    int unsigned         ph_items;
    int unsigned         rand_count;
    rand_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      configure(DIR_ROWS[i].mode, DIR_ROWS[i].len);
      send_sample(DIR_ROWS[i].sample, DIR_ROWS[i].typed, DIR_ROWS[i].result);
    end

    cap_fix = CAPLEN_W'($urandom_range(64, 512));
    while (rand_count < RANDOM_ITEMS || !cap_done) begin
      if (!cap_done && $urandom_range(0, 1) == 1) ph_mode = MODE_FREEZE;
      else ph_mode = MODE_W'($urandom_range(0, 7));
      if (!cap_done) begin
        ph_len = cap_fix;
      end else begin
        case ($urandom_range(0, 7))
          0:       ph_len = '0;
          1:       ph_len = 12'd1;
          2:       ph_len = cap_fix;
          3:       ph_len = cap_fix - 12'd1;
          4, 5:    ph_len = CAPLEN_W'($urandom_range(1, 40));
          default: ph_len = CAPLEN_W'($urandom_range(0, cap_fix));
        endcase
      end
      case (ph_mode)
        MODE_AVGL:           ph_items = $urandom_range(130, 400);
        MODE_AVG2, MODE_AVG8: ph_items = $urandom_range(10, 80);
        MODE_FREEZE:         ph_items = cap_done ? $urandom_range(5, 200)
                                                 : $urandom_range(150, 400);
        default:             ph_items = $urandom_range(5, 30);
      endcase
      run_phase(ph_mode, ph_len, ph_items, rand_count);
    end

    idle_on = 1'b0;
    run_phase(MODE_W'($urandom_range(0, 7)), CAPLEN_W'($urandom_range(1, 40)), 200,
              rand_count);

    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
